// File: rtl/kra_pkg.sv
// package for the key repeat accelerator: constants, register indexes and control types
package kra_pkg;

    // fixed field widths
    localparam int VALUE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_W      = 20;
    localparam int CFG_RATE_W = 12;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PAIR_W     = 4;

    localparam logic [PAIR_W-1:0] MAX_PAIRS = 4'd15;

    // default fraction bits of the rate
    localparam int DEF_RATE_FRAC_BITS = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_MODE = 3'd4;

    // register reset values
    localparam logic [CFG_RATE_W-1:0] RST_ACCEL_RATE   = 12'd576;
    localparam logic [CFG_RATE_W-1:0] RST_MAX_RATE     = 12'd3840;
    localparam logic [DELAY_W-1:0]    RST_MAX_DELAY_MS = 16'd300;
    localparam logic [COUNT_W-1:0]    RST_MIN_PRESSES  = 8'd2;
    localparam logic                  RST_RELATIVE     = 1'b0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;       // capture the input transaction
        logic update;      // gap check, press count and rate update
        logic prep;        // product or overhead accumulation
        logic load_first;  // load the first result
        logic load_rel;    // load a release result
        logic load_press;  // load a repeated press result
        logic finish;      // clamp overhead after the last result
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_last;    // result held in the output register is the final one
    } t_dp_status;

endpackage

// File: rtl/key_repeat_accelerator.sv
// top level of the key repeat accelerator: stream ports, register port, controller and datapath
//
// Each input transaction carries an event value and a millisecond timestamp. When the gap since
// the previous event exceeds max_delay_ms the acceleration state is cleared and the value passes
// through as one result. A press (+1 or -1) within the window raises the press count and, once
// min_presses is reached, grows the rate by accel_rate up to max_rate. In relative mode one
// result carries the value times the rate rounded half up; in key mode the rate is added to the
// overhead, the value is sent, and then up to 15 release/press pairs (0, value) follow while the
// overhead exceeds 1.0. Any other value passes through. tlast marks the final result of each input.
// Sequence per input: accept, update, prepare and first load, then the results, n of them (1 to 31).
// The result sequencer delivers one result a cycle from the output register while the output side
// is ready, and takes the next input only after the final result of the current one has left.
// The configuration port is always ready; write registers only while the block is idle.
module key_repeat_accelerator #(
    parameter int RATE_FRAC_BITS = kra_pkg::DEF_RATE_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input events
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] event_value (signed), [47:16] time_ms
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [19:0] out_value (signed), [23:20] zero
    output logic        o_m_axis_tlast,   // last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [kra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kra_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    kra_pkg::t_dp_cmd    w_cmd;
    kra_pkg::t_dp_status w_status;
    logic [kra_pkg::OUT_W-1:0] w_out_value;

    // registers accept a transaction in any cycle
    assign o_cfg_ready = 1'b1;

    kra_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    kra_datapath #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_event_value (i_s_axis_tdata[15:0]),
        .i_time_ms     (i_s_axis_tdata[47:16]),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_value   (w_out_value),
        .o_last        (o_m_axis_tlast)
    );

    // pad the result to whole bytes
    assign o_m_axis_tdata = {4'b0000, w_out_value};

endmodule

// File: rtl/kra_datapath.sv
// datapath of the key repeat accelerator: registers, state, rate arithmetic and output register
module kra_datapath #(
    parameter int RATE_FRAC_BITS = kra_pkg::DEF_RATE_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [kra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kra_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [kra_pkg::VALUE_W-1:0]     i_event_value,
    input  logic [kra_pkg::TIME_W-1:0]      i_time_ms,
    input  kra_pkg::t_dp_cmd                i_cmd,
    output kra_pkg::t_dp_status             o_status,
    output logic [kra_pkg::OUT_W-1:0]       o_out_value,
    output logic                            o_last
);

    localparam int RateW  = (RATE_FRAC_BITS + 1 > kra_pkg::CFG_RATE_W) ?
                            RATE_FRAC_BITS + 1 : kra_pkg::CFG_RATE_W;
    localparam int OvhW   = RateW + 1;
    localparam int MultW  = RateW + 1 - RATE_FRAC_BITS;

    localparam logic [OvhW-1:0] One  = {{(OvhW-1){1'b0}}, 1'b1} << RATE_FRAC_BITS;
    localparam logic [OvhW-1:0] Half = {{(OvhW-1){1'b0}}, 1'b1} << (RATE_FRAC_BITS - 1);

    // configuration registers
    logic [kra_pkg::CFG_RATE_W-1:0] r_accel_rate;
    logic [kra_pkg::CFG_RATE_W-1:0] r_max_rate;
    logic [kra_pkg::DELAY_W-1:0]    r_max_delay;
    logic [kra_pkg::COUNT_W-1:0]    r_min_presses;
    logic                           r_relative;

    // block state
    logic [kra_pkg::COUNT_W-1:0]    r_count;
    logic [RateW-1:0]               r_rate;
    logic [OvhW-1:0]                r_ovh;
    logic [kra_pkg::TIME_W-1:0]     r_last_time;

    // per transaction
    logic signed [kra_pkg::VALUE_W-1:0] r_v;
    logic [kra_pkg::TIME_W-1:0]         r_t;
    logic                               r_pass;
    logic [kra_pkg::PAIR_W-1:0]         r_pairs;
    logic signed [kra_pkg::OUT_W-1:0]   r_prod;
    logic [kra_pkg::OUT_W-1:0]          r_out;
    logic                               r_out_last;

    logic [kra_pkg::TIME_W-1:0]         w_gap;
    logic                               w_long;
    logic                               w_press;
    logic [kra_pkg::COUNT_W-1:0]        n_count;
    logic [RateW:0]                     w_sum;
    logic [RateW:0]                     w_max_ext;
    logic [RateW-1:0]                   n_rate;
    logic [OvhW-1:0]                    w_round;
    logic [MultW-1:0]                   w_mult;
    logic signed [kra_pkg::OUT_W-1:0]   w_v_ext;
    logic signed [kra_pkg::OUT_W-1:0]   w_m_ext;
    logic signed [kra_pkg::OUT_W-1:0]   w_prod;
    logic                               w_more;

    always_comb begin
        w_gap     = r_t - r_last_time;
        w_long    = w_gap > {{(kra_pkg::TIME_W-kra_pkg::DELAY_W){1'b0}}, r_max_delay};
        w_press   = (r_v == 16'sd1) || (r_v == -16'sd1);
        n_count   = (r_count != {kra_pkg::COUNT_W{1'b1}}) ? r_count + 8'd1 : r_count;
        w_sum     = {1'b0, r_rate} + (RateW+1)'(r_accel_rate);
        w_max_ext = (RateW+1)'(r_max_rate);
        n_rate    = (w_sum > w_max_ext) ? RateW'(r_max_rate) : w_sum[RateW-1:0];
        w_round   = {1'b0, r_rate} + Half;
        w_mult    = w_round[RateW:RATE_FRAC_BITS];
        w_v_ext   = kra_pkg::OUT_W'(r_v);
        w_m_ext   = $signed(kra_pkg::OUT_W'(w_mult));
        w_prod    = w_v_ext * w_m_ext;
        w_more    = (r_ovh > One) && (r_pairs != kra_pkg::MAX_PAIRS);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate  <= kra_pkg::RST_ACCEL_RATE;
            r_max_rate    <= kra_pkg::RST_MAX_RATE;
            r_max_delay   <= kra_pkg::RST_MAX_DELAY_MS;
            r_min_presses <= kra_pkg::RST_MIN_PRESSES;
            r_relative    <= kra_pkg::RST_RELATIVE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kra_pkg::REG_ACCEL_RATE:    r_accel_rate  <= i_cfg_data[kra_pkg::CFG_RATE_W-1:0];
                kra_pkg::REG_MAX_RATE:      r_max_rate    <= i_cfg_data[kra_pkg::CFG_RATE_W-1:0];
                kra_pkg::REG_MAX_DELAY_MS:  r_max_delay   <= i_cfg_data;
                kra_pkg::REG_MIN_PRESSES:   r_min_presses <= i_cfg_data[kra_pkg::COUNT_W-1:0];
                kra_pkg::REG_RELATIVE_MODE: r_relative    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // acceleration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rate      <= One[RateW-1:0];
            r_ovh       <= '0;
            r_last_time <= '0;
        end else begin
            if (i_cmd.update) begin
                r_last_time <= r_t;
                if (w_long) begin
                    r_count <= '0;
                    r_rate  <= One[RateW-1:0];
                    r_ovh   <= '0;
                end else if (w_press) begin
                    r_count <= n_count;
                    if (n_count >= r_min_presses) begin
                        r_rate <= n_rate;
                    end
                end
            end
            if (i_cmd.prep && !r_pass && !r_relative) begin
                r_ovh <= r_ovh + OvhW'(r_rate);
            end
            if (i_cmd.load_rel) begin
                r_ovh <= r_ovh - One;
            end
            if (i_cmd.finish && (r_ovh > One)) begin
                r_ovh <= One;
            end
        end
    end

    // transaction payload and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_v <= $signed(i_event_value);
            r_t <= i_time_ms;
        end
        if (i_cmd.update) begin
            r_pass <= w_long || !w_press;
        end
        if (i_cmd.prep) begin
            r_prod  <= w_prod;
            r_pairs <= '0;
        end
        if (i_cmd.load_first) begin
            r_out      <= (!r_pass && r_relative) ? r_prod : w_v_ext;
            r_out_last <= r_pass || r_relative || !w_more;
        end
        if (i_cmd.load_rel) begin
            r_out      <= '0;
            r_out_last <= 1'b0;
            r_pairs    <= r_pairs + 4'd1;
        end
        if (i_cmd.load_press) begin
            r_out      <= w_v_ext;
            r_out_last <= !w_more;
        end
    end

    assign o_out_value       = r_out;
    assign o_last            = r_out_last;
    assign o_status.out_last = r_out_last;

endmodule

// File: rtl/kra_controller.sv
// controller state machine of the key repeat accelerator
module kra_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  kra_pkg::t_dp_status  i_status,
    output kra_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_PREP,
        S_FIRST,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_valid;
    logic   r_rel_sent;
    logic   w_in_acc;
    logic   w_out_acc;

    assign w_in_acc  = i_in_valid && r_in_ready;
    assign w_out_acc = r_valid && i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.latch      = w_in_acc;
        o_cmd.update     = (r_state == S_UPD);
        o_cmd.prep       = (r_state == S_PREP);
        o_cmd.load_first = (r_state == S_FIRST);
        if ((r_state == S_SEND) && w_out_acc) begin
            o_cmd.finish     = i_status.out_last;
            o_cmd.load_rel   = !i_status.out_last && !r_rel_sent;
            o_cmd.load_press = !i_status.out_last && r_rel_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_valid    <= 1'b0;
            r_rel_sent <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state <= S_FIRST;
                end
                S_FIRST: begin
                    r_valid    <= 1'b1;
                    r_rel_sent <= 1'b0;
                    r_state    <= S_SEND;
                end
                S_SEND: begin
                    if (w_out_acc) begin
                        if (i_status.out_last) begin
                            r_valid    <= 1'b0;
                            r_in_ready <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_rel_sent <= !r_rel_sent;
                        end
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                    r_valid    <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_valid;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_valid && r_in_ready))
        else $error("input ready while a result is pending");

    a_send_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> r_valid)
        else $error("send state without a valid result");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_UPD))
        else $error("accepted transaction not followed by update");

    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && i_status.out_last) |=> (r_in_ready && !r_valid))
        else $error("block not ready after the final result");

    a_more_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !i_status.out_last) |=> r_valid)
        else $error("result stream cut before the final result");
`endif

endmodule
